@@ src/ntt_pkg.sv @@
// Package for the length-256 NTT unit over Z_3329: constants, types, twiddle table
// and modular helper functions. No dependencies.
`default_nettype none
package ntt_pkg;
  localparam int unsigned Q = 3329;
  localparam logic [11:0] Q12 = 12'd3329;
  localparam logic [11:0] SCALE = 12'd3303;
  // floor(2^36 / 3329), Barrett constant for products below 3329^2
  localparam logic [24:0] BARRETT_M = 25'd20642678;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;
  localparam logic DIR_FWD  = 1'b0;
  localparam logic DIR_INV  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_BF_RD, ST_BF_MUL, ST_BF_QT, ST_BF_WRA, ST_BF_WRB,
    ST_SC_RD, ST_SC_MUL, ST_SC_QT, ST_SC_WR, ST_DONE
  } ntt_state_t;

  // zeta^brv7(k) mod 3329
  function automatic logic [11:0] twiddle(input logic [6:0] k);
    logic [11:0] t;
    case (k)
      7'd0: t=12'd1; 7'd1: t=12'd1729; 7'd2: t=12'd2580; 7'd3: t=12'd3289;
      7'd4: t=12'd2642; 7'd5: t=12'd630; 7'd6: t=12'd1897; 7'd7: t=12'd848;
      7'd8: t=12'd1062; 7'd9: t=12'd1919; 7'd10: t=12'd193; 7'd11: t=12'd797;
      7'd12: t=12'd2786; 7'd13: t=12'd3260; 7'd14: t=12'd569; 7'd15: t=12'd1746;
      7'd16: t=12'd296; 7'd17: t=12'd2447; 7'd18: t=12'd1339; 7'd19: t=12'd1476;
      7'd20: t=12'd3046; 7'd21: t=12'd56; 7'd22: t=12'd2240; 7'd23: t=12'd1333;
      7'd24: t=12'd1426; 7'd25: t=12'd2094; 7'd26: t=12'd535; 7'd27: t=12'd2882;
      7'd28: t=12'd2393; 7'd29: t=12'd2879; 7'd30: t=12'd1974; 7'd31: t=12'd821;
      7'd32: t=12'd289; 7'd33: t=12'd331; 7'd34: t=12'd3253; 7'd35: t=12'd1756;
      7'd36: t=12'd1197; 7'd37: t=12'd2304; 7'd38: t=12'd2277; 7'd39: t=12'd2055;
      7'd40: t=12'd650; 7'd41: t=12'd1977; 7'd42: t=12'd2513; 7'd43: t=12'd632;
      7'd44: t=12'd2865; 7'd45: t=12'd33; 7'd46: t=12'd1320; 7'd47: t=12'd1915;
      7'd48: t=12'd2319; 7'd49: t=12'd1435; 7'd50: t=12'd807; 7'd51: t=12'd452;
      7'd52: t=12'd1438; 7'd53: t=12'd2868; 7'd54: t=12'd1534; 7'd55: t=12'd2402;
      7'd56: t=12'd2647; 7'd57: t=12'd2617; 7'd58: t=12'd1481; 7'd59: t=12'd648;
      7'd60: t=12'd2474; 7'd61: t=12'd3110; 7'd62: t=12'd1227; 7'd63: t=12'd910;
      7'd64: t=12'd17; 7'd65: t=12'd2761; 7'd66: t=12'd583; 7'd67: t=12'd2649;
      7'd68: t=12'd1637; 7'd69: t=12'd723; 7'd70: t=12'd2288; 7'd71: t=12'd1100;
      7'd72: t=12'd1409; 7'd73: t=12'd2662; 7'd74: t=12'd3281; 7'd75: t=12'd233;
      7'd76: t=12'd756; 7'd77: t=12'd2156; 7'd78: t=12'd3015; 7'd79: t=12'd3050;
      7'd80: t=12'd1703; 7'd81: t=12'd1651; 7'd82: t=12'd2789; 7'd83: t=12'd1789;
      7'd84: t=12'd1847; 7'd85: t=12'd952; 7'd86: t=12'd1461; 7'd87: t=12'd2687;
      7'd88: t=12'd939; 7'd89: t=12'd2308; 7'd90: t=12'd2437; 7'd91: t=12'd2388;
      7'd92: t=12'd733; 7'd93: t=12'd2337; 7'd94: t=12'd268; 7'd95: t=12'd641;
      7'd96: t=12'd1584; 7'd97: t=12'd2298; 7'd98: t=12'd2037; 7'd99: t=12'd3220;
      7'd100: t=12'd375; 7'd101: t=12'd2549; 7'd102: t=12'd2090; 7'd103: t=12'd1645;
      7'd104: t=12'd1063; 7'd105: t=12'd319; 7'd106: t=12'd2773; 7'd107: t=12'd757;
      7'd108: t=12'd2099; 7'd109: t=12'd561; 7'd110: t=12'd2466; 7'd111: t=12'd2594;
      7'd112: t=12'd2804; 7'd113: t=12'd1092; 7'd114: t=12'd403; 7'd115: t=12'd1026;
      7'd116: t=12'd1143; 7'd117: t=12'd2150; 7'd118: t=12'd2775; 7'd119: t=12'd886;
      7'd120: t=12'd1722; 7'd121: t=12'd1212; 7'd122: t=12'd1874; 7'd123: t=12'd1029;
      7'd124: t=12'd2110; 7'd125: t=12'd2935; 7'd126: t=12'd885; 7'd127: t=12'd2154;
      default: t = 12'd1;
    endcase
    return t;
  endfunction

  // Reduce a 13-bit value (< 2*Q) into 0..Q-1.
  function automatic logic [11:0] red1(input logic [12:0] a);
    return (a >= 13'(Q)) ? 12'(a - 13'(Q)) : a[11:0];
  endfunction

  function automatic logic [11:0] addq(input logic [11:0] a, input logic [11:0] b);
    return red1({1'b0, a} + {1'b0, b});
  endfunction

  function automatic logic [11:0] subq(input logic [11:0] a, input logic [11:0] b);
    return red1({1'b0, a} + 13'(Q) - {1'b0, b});
  endfunction

  // Barrett quotient estimate of a product < 3329^2; at most one below the true one.
  function automatic logic [11:0] barrett_q(input logic [23:0] p);
    logic [47:0] qe;
    qe = 48'(p) * 48'(BARRETT_M);
    return qe[47:36];
  endfunction

  // Remainder from the product and its quotient estimate; lands below 2*Q first.
  function automatic logic [11:0] barrett_fix(input logic [23:0] p, input logic [11:0] qt);
    logic [23:0] r;
    r = p - 24'(qt) * 24'(Q);
    return red1(r[12:0]);
  endfunction
endpackage
`default_nettype wire

@@ src/ntt_if.sv @@
// Valid/ready channel interface with generic payload type.
// Depends on nothing.
`default_nettype none
interface ntt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/ntt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module ntt_ram #(
  parameter int Width = 12,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]              rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ src/ntt_forward_inverse_q3329_unit.sv @@
// Top level of the length-256 NTT unit over Z_3329 (forward and inverse).
// Uses ntt_pkg, ntt_ram; ports are flattened valid/ready channels and an APB port.
//
// Load 256 coefficients (action 0), each reduced mod 3329 on entry; the 256th
// load starts the transform chosen by the direction register (0 forward
// Cooley-Tukey, 1 inverse Gentleman-Sande plus scaling by 3303). Two RAMs of
// 256 x 12 hold identical copies of the polynomial, so both butterfly operands
// are read in the same cycle; every write goes to both. A butterfly steps through
// read, multiply by the twiddle, Barrett quotient, write the first output and
// write the second output. After the 896 butterflies the inverse scales all 256
// coefficients (read, multiply, quotient, write); then a done state raises the
// ready flag. No item is taken from the 256th load until the transform is done.
// Otherwise one load or read is taken per cycle; a read's result is valid the
// cycle after it is accepted and holds while out_ready is low, which also holds
// off the next item. A read before a transform completes returns zero with
// not_ready set.
`default_nettype none
module ntt_forward_inverse_q3329_unit
  import ntt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [11:0] in_coeff_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_coeff_out,
  output logic [7:0]       out_index,
  output logic             out_last,
  output logic             out_not_ready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [0:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  // Polynomial lives in the RAMs; butterfly work is read/modify/write.
  ntt_state_t state_r, state_nxt;
  logic       dir_r, dir_run_r;
  logic [7:0] load_cnt_r;
  logic [7:0] read_cnt_r;
  logic       ready_r;
  logic [2:0] layer_r;    // 0..6
  logic [6:0] bf_r;       // butterfly number within layer
  logic [7:0] sc_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, dir_r};
  always_ff @(posedge clk) begin
    if (!rst_n) dir_r <= DIR_FWD;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) dir_r <= cfg_pwdata[0];
  end

  // Butterfly address: len = 128 >> layer (forward) or 2 << layer (inverse).
  logic [2:0] lsh;        // log2(len)
  logic [7:0] mask, a_idx, b_idx, grp;
  logic [6:0] kidx;
  always_comb begin
    lsh  = (dir_run_r == DIR_FWD) ? 3'(7 - layer_r) : 3'(layer_r + 1);
    mask = 8'((9'd1 << lsh) - 9'd1);
    grp  = 8'({1'b0, bf_r} >> lsh);
    a_idx = ({1'b0, bf_r} & mask) | (grp << (4'(lsh) + 4'd1));
    b_idx = a_idx | 8'(9'd1 << lsh);
    if (dir_run_r == DIR_FWD) kidx = 7'((8'd1 << layer_r) + grp);
    else kidx = 7'((8'd128 >> layer_r) - 8'd1 - grp);
  end
  // For inverse, k at layer L and group g: 127 - (groups in earlier layers) - g,
  // and the earlier layers hold 128 - (128 >> L) groups.

  logic        we;
  logic [7:0]  waddr, raddr, ra2;
  logic [11:0] wdata, rdata, rd2;

  ntt_ram #(.Width(12), .Depth(256)) u_ram_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));
  ntt_ram #(.Width(12), .Depth(256)) u_ram_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(ra2), .rdata(rd2));

  logic [7:0]  a_r, b_r;
  logic [11:0] z_r;
  logic [23:0] prod_r;
  logic [11:0] qt_r;
  logic [11:0] x_r, y_r;
  logic [11:0] bw_val_r;
  logic        in_fire, out_fire, rd_fire;
  logic        ov_r, ov_nxt, olast_r, onr_r, ordpend_r;
  logic [7:0]  oidx_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign rd_fire  = in_fire && in_action == ACT_READ;
  assign in_ready = (state_r == ST_LOAD) && (!ov_r || out_ready);

  // Output register: drop on accept, set by an accepted read.
  always_comb begin
    ov_nxt = ov_r;
    if (out_fire) ov_nxt = 1'b0;
    if (rd_fire) ov_nxt = 1'b1;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:   if (in_fire && in_action == ACT_LOAD && load_cnt_r == 8'd255) state_nxt = ST_BF_RD;
      ST_BF_RD:  state_nxt = ST_BF_MUL;
      ST_BF_MUL: state_nxt = ST_BF_QT;
      ST_BF_QT:  state_nxt = ST_BF_WRA;
      ST_BF_WRA: state_nxt = ST_BF_WRB;
      ST_BF_WRB: if (bf_r == 7'd127 && layer_r == 3'd6)
                   state_nxt = (dir_run_r == DIR_INV) ? ST_SC_RD : ST_DONE;
                 else state_nxt = ST_BF_RD;
      ST_SC_RD:  state_nxt = ST_SC_MUL;
      ST_SC_MUL: state_nxt = ST_SC_QT;
      ST_SC_QT:  state_nxt = ST_SC_WR;
      ST_SC_WR:  state_nxt = (sc_r == 8'd255) ? ST_DONE : ST_SC_RD;
      ST_DONE:   state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // Memory port control
  logic [11:0] ld_val, tw_prod, bfx, bfy;
  always_comb begin
    ld_val  = red1({1'b0, in_coeff_in});
    tw_prod = barrett_fix(prod_r, qt_r);
    if (dir_run_r == DIR_FWD) begin
      bfx = addq(x_r, tw_prod);
      bfy = subq(x_r, tw_prod);
    end else begin
      bfx = addq(x_r, y_r);
      bfy = tw_prod;
    end
    we = 1'b0; waddr = load_cnt_r; wdata = ld_val;
    // Hold the read address of a stalled result so its data stays put.
    raddr = (ov_r && !out_ready) ? oidx_r : read_cnt_r;
    ra2 = b_idx;
    case (state_r)
      ST_LOAD:   we = in_fire && in_action == ACT_LOAD;
      ST_BF_RD:  begin raddr = a_idx; ra2 = b_idx; end
      ST_BF_WRA: begin we = 1'b1; waddr = a_r; wdata = bfx; end
      ST_BF_WRB: begin we = 1'b1; waddr = b_r; wdata = bw_val_r; end
      ST_SC_RD:  raddr = sc_r;
      ST_SC_WR:  begin we = 1'b1; waddr = sc_r; wdata = tw_prod; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; load_cnt_r <= '0; read_cnt_r <= '0; ready_r <= 1'b0;
      layer_r <= '0; bf_r <= '0; sc_r <= '0; dir_run_r <= DIR_FWD;
      ov_r <= 1'b0; ordpend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      case (state_r)
        ST_LOAD: if (in_fire) begin
          if (in_action == ACT_LOAD) begin
            ready_r <= 1'b0; read_cnt_r <= '0;
            load_cnt_r <= load_cnt_r + 8'd1;   // wraps to 0 on the 256th load
            if (load_cnt_r == 8'd255) begin
              dir_run_r <= dir_r; layer_r <= '0; bf_r <= '0; sc_r <= '0;
            end
          end else begin
            ordpend_r <= ready_r;
            oidx_r <= ready_r ? read_cnt_r : 8'd0;
            olast_r <= ready_r && read_cnt_r == 8'd255;
            onr_r <= !ready_r;
            if (ready_r) begin
              if (read_cnt_r == 8'd255) ready_r <= 1'b0;
              read_cnt_r <= read_cnt_r + 8'd1;
            end
          end
        end
        ST_BF_RD: begin a_r <= a_idx; b_r <= b_idx; z_r <= twiddle(kidx); end
        ST_BF_MUL: begin
          x_r <= rdata; y_r <= rd2;
          prod_r <= (dir_run_r == DIR_FWD) ? {12'd0, z_r} * {12'd0, rd2}
                                           : {12'd0, z_r} * {12'd0, subq(rd2, rdata)};
        end
        ST_BF_QT:  qt_r <= barrett_q(prod_r);
        ST_BF_WRA: bw_val_r <= bfy;
        ST_BF_WRB: begin
          if (bf_r == 7'd127) begin
            bf_r <= '0;
            layer_r <= (layer_r == 3'd6) ? 3'd0 : layer_r + 3'd1;
          end else bf_r <= bf_r + 7'd1;
        end
        ST_SC_RD:  ;
        ST_SC_MUL: prod_r <= {12'd0, rdata} * {12'd0, SCALE};
        ST_SC_QT:  qt_r <= barrett_q(prod_r);
        ST_SC_WR:  sc_r <= sc_r + 8'd1;
        ST_DONE:   ready_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_valid     = ov_r;
  assign out_coeff_out = ordpend_r ? rdata : 12'd0;
  assign out_index     = oidx_r;
  assign out_last      = olast_r;
  assign out_not_ready = onr_r;

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ready) |-> !in_ready) else $error("new item taken while result stalls");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_coeff_out) && $stable(out_index))
    else $error("result changed while stalled");
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> load_cnt_r == 8'd0) else $error("load count not cleared in transform");
  a_nr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_not_ready && out_last)) else $error("last on early read");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |=> ready_r) else $error("ready not set after transform");
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the length-256 NTT unit over Z_3329 (forward and inverse transform).
// Depends on ntt_pkg, ntt_if and ntt_forward_inverse_q3329_unit; predicts every read
// result with its own transform and checks it field by field.
`timescale 1ns / 1ps
module tb;
  import ntt_pkg::*;

  typedef struct packed {
    logic        action;
    logic [11:0] coeff;
  } load_item_t;

  typedef struct packed {
    logic [11:0] coeff;
    logic [7:0]  index;
    logic        last;
    logic        not_ready;
  } coeff_result_t;

  localparam int CYCLE_LIMIT = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ntt_if #(.T(load_item_t))    in_ch ();
  ntt_if #(.T(coeff_result_t)) out_ch ();

  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [0:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ntt_forward_inverse_q3329_unit u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_action     (in_ch.data.action),
    .in_coeff_in   (in_ch.data.coeff),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_coeff_out (out_ch.data.coeff),
    .out_index     (out_ch.data.index),
    .out_last      (out_ch.data.last),
    .out_not_ready (out_ch.data.not_ready),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  // 12 ns period: 6 high, 6 low.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: the polynomial store, counters and the direction register.
  int            poly [256];
  int            zeta [128];
  int unsigned   fill_cnt;
  int unsigned   drain_cnt;
  bit            poly_ready;
  bit            dir_inverse;
  coeff_result_t pending_results [$];

  int  errors = 0;
  int  loads_sent = 0;
  int  reads_sent = 0;
  int  results_seen = 0;
  int  cycles = 0;
  int  out_hold = 0;

  // zeta = 17 raised to the 7-bit bit-reversal of k.
  function automatic int zeta_brv(input int k);
    int e;
    int r;
    e = 0;
    r = 1;
    for (int b = 0; b < 7; b++)
      if ((k >> b) & 1) e |= 1 << (6 - b);
    for (int i = 0; i < e; i++) r = (r * 17) % Q;
    return r;
  endfunction

  // Cooley-Tukey layers, longest stride first.
  function automatic void ntt_forward();
    int k;
    int t;
    int a;
    k = 1;
    for (int len = 128; len >= 2; len >>= 1)
      for (int s = 0; s < 256; s += 2 * len) begin
        for (int j = s; j < s + len; j++) begin
          t = (zeta[k] * poly[j + len]) % Q;
          a = poly[j];
          poly[j + len] = (a + Q - t) % Q;
          poly[j] = (a + t) % Q;
        end
        k++;
      end
  endfunction

  // Gentleman-Sande layers, then scale by 128^-1.
  function automatic void ntt_inverse();
    int k;
    int a;
    int b;
    k = 127;
    for (int len = 2; len <= 128; len <<= 1)
      for (int s = 0; s < 256; s += 2 * len) begin
        for (int j = s; j < s + len; j++) begin
          a = poly[j];
          b = poly[j + len];
          poly[j] = (a + b) % Q;
          poly[j + len] = (zeta[k] * ((b + Q - a) % Q)) % Q;
        end
        k--;
      end
    for (int j = 0; j < 256; j++) poly[j] = (poly[j] * int'(SCALE)) % Q;
  endfunction

  // Advance the predictor by one accepted item; queue the result a read causes.
  function automatic void predict_item(input load_item_t it);
    coeff_result_t r;
    if (it.action == ACT_LOAD) begin
      // A load drops any polynomial still being read out.
      poly_ready = 1'b0;
      drain_cnt = 0;
      poly[fill_cnt] = int'(it.coeff) % Q;
      fill_cnt++;
      if (fill_cnt == 256) begin
        if (dir_inverse) ntt_inverse();
        else ntt_forward();
        fill_cnt = 0;
        drain_cnt = 0;
        poly_ready = 1'b1;
      end
    end else if (!poly_ready) begin
      // Early read: zero with the not-ready flag, nothing moves.
      r = '{coeff: '0, index: '0, last: 1'b0, not_ready: 1'b1};
      pending_results.push_back(r);
    end else begin
      r = '{coeff: 12'(poly[drain_cnt]), index: 8'(drain_cnt),
            last: (drain_cnt == 255), not_ready: 1'b0};
      pending_results.push_back(r);
      if (drain_cnt == 255) begin
        drain_cnt = 0;
        poly_ready = 1'b0;
      end else begin
        drain_cnt++;
      end
    end
  endfunction

  // Send one item: idle a random gap, hold valid until accepted, return at a falling edge.
  task automatic send_item(input logic action, input logic [11:0] coeff);
    int gap;
    load_item_t it;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    it = '{action: action, coeff: coeff};
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(it);
    if (action == ACT_LOAD) loads_sent++;
    else reads_sent++;
    @(negedge clk);
  endtask

  // Drain everything outstanding, let the transform settle, then write direction.
  task automatic write_direction(input bit inverse);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    do @(posedge clk); while (!in_ch.ready);
    repeat (8) @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= {31'($urandom_range(0, 32'h7fff_ffff)), inverse};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    dir_inverse = inverse;
    if (cfg_prdata[0] !== inverse || cfg_pready !== 1'b1) begin
      $error("direction: expected %0b, got %0b", inverse, cfg_prdata[0]);
      errors++;
    end
    @(negedge clk);
  endtask

  task automatic read_out(input int n);
    for (int i = 0; i < n; i++) send_item(ACT_READ, 12'($urandom_range(0, 4095)));
  endtask

  task automatic test_early_read();
    read_out(3);
  endtask

  // Inverse transform with early reads mid-fill; the readout is cut short later.
  task automatic test_inverse_discard();
    write_direction(DIR_INV);
    for (int i = 0; i < 256; i++) begin
      send_item(ACT_LOAD, 12'($urandom_range(0, 4095)));
      if (i == 10 || i == 200) send_item(ACT_READ, '0);
    end
    read_out(10);
  endtask

  // Forward transform of field extremes; the first load drops the pending readout.
  task automatic test_forward_extremes();
    logic [11:0] pick [6];
    pick = '{12'd0, 12'd4095, 12'd3328, 12'd3329, 12'd1, 12'd2048};
    write_direction(DIR_FWD);
    for (int i = 0; i < 256; i++)
      send_item(ACT_LOAD, (i % 7 == 6) ? 12'($urandom_range(0, 4095)) : pick[i % 7 % 6]);
    read_out(257);
  endtask

  // Receiver: draw a stall after each result.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_ch.ready <= 1'b0;
      out_hold--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    coeff_result_t exp_r;
    coeff_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      results_seen++;
      out_hold <= $urandom_range(0, 7);
      if (pending_results.size() == 0) begin
        $error("unexpected result: coeff %0d index %0d", got.coeff, got.index);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got.coeff !== exp_r.coeff) begin
          $error("coeff_out: expected %0d, got %0d", exp_r.coeff, got.coeff);
          errors++;
        end
        if (got.index !== exp_r.index) begin
          $error("index: expected %0d, got %0d", exp_r.index, got.index);
          errors++;
        end
        if (got.last !== exp_r.last) begin
          $error("last: expected %0b, got %0b", exp_r.last, got.last);
          errors++;
        end
        if (got.not_ready !== exp_r.not_ready) begin
          $error("not_ready: expected %0b, got %0b", exp_r.not_ready, got.not_ready);
          errors++;
        end
      end
    end
  end

  // Hard stop if the block hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < 128; k++) zeta[k] = zeta_brv(k);
    fill_cnt = 0;
    drain_cnt = 0;
    poly_ready = 1'b0;
    dir_inverse = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_early_read();
    test_inverse_discard();
    test_forward_extremes();

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("sent %0d loads and %0d reads, checked %0d results over %0d cycles",
             loads_sent, reads_sent, results_seen, cycles);
    $display("both directions, early reads, readout past the end and mid-readout reloads");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

@@ sim.f @@
src/ntt_pkg.sv
src/ntt_if.sv
src/ntt_ram.sv
src/ntt_forward_inverse_q3329_unit.sv
verif/tb.sv
